/* design/fbta_pkg.sv */
// package for the first-fit boundary-tag allocator
// holds item types, sequencer states, tag constants; no dependencies
`timescale 1ns / 1ps

package fbta_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 16384;
  localparam logic [31:0] HDR_BYTES = 32'd16;
  localparam logic [31:0] FTR_BYTES = 32'd4;
  localparam logic [31:0] MIN_BLOCK = 32'd24;
  localparam logic [31:0] LINK_VALID = 32'h8000_0000;
  localparam logic [2:0] REG_HEAP_BASE = 3'd0;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [14:0] req_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_address;
  } rsp_t;

  typedef enum logic [42:0] {
    S_IDLE  = 43'h1 << 0,
    S_INIT  = 43'h1 << 1,
    A_RD    = 43'h1 << 2,
    A_SZ    = 43'h1 << 3,
    A_NX    = 43'h1 << 4,
    A_FL0   = 43'h1 << 5,
    A_FL1   = 43'h1 << 6,
    P_W0    = 43'h1 << 7,
    P_F0    = 43'h1 << 8,
    P_F1    = 43'h1 << 9,
    P_W2    = 43'h1 << 10,
    P_W3    = 43'h1 << 11,
    P_F2    = 43'h1 << 12,
    P_F3    = 43'h1 << 13,
    P_W4    = 43'h1 << 14,
    P_P     = 43'h1 << 15,
    P_X     = 43'h1 << 16,
    P_Y     = 43'h1 << 17,
    P_Z     = 43'h1 << 18,
    P_PW    = 43'h1 << 19,
    P_XW    = 43'h1 << 20,
    U_P     = 43'h1 << 21,
    U_X     = 43'h1 << 22,
    U_W1    = 43'h1 << 23,
    U_W2    = 43'h1 << 24,
    J_0     = 43'h1 << 25,
    J_1     = 43'h1 << 26,
    J_2     = 43'h1 << 27,
    J_3     = 43'h1 << 28,
    F_RF    = 43'h1 << 29,
    F_FL    = 43'h1 << 30,
    F_RS    = 43'h1 << 31,
    F_SZ    = 43'h1 << 32,
    F_NF    = 43'h1 << 33,
    F_PV    = 43'h1 << 34,
    F_PF    = 43'h1 << 35,
    F_PF2   = 43'h1 << 36,
    F_MG    = 43'h1 << 37,
    F_J1    = 43'h1 << 38,
    F_J2    = 43'h1 << 39,
    F_PUSH  = 43'h1 << 40,
    F_P2    = 43'h1 << 41,
    F_P3    = 43'h1 << 42
  } state_t;

endpackage

/* design/first_fit_boundary_tag_allocator.sv */
// top level of the first-fit boundary-tag heap allocator: apb register and sequencer
// depends on fbta_pkg and fbta_seq
`timescale 1ns / 1ps

// Heap allocator over an internal word memory with boundary tags and an explicit
// free list. Raise start with an item while busy is low; one result comes back on
// result, marked by done for exactly one cycle, and cannot be stalled. All work
// goes through a single memory port, one access per cycle. A request rejected up
// front never raises busy and is answered in the next cycle. An allocate walks the
// free list past each block that is too small, then splits the fitting block or
// takes it whole; how long a free stays busy depends on coalescing. done rises in
// the same cycle as busy drops. After reset the block is busy while it writes the
// initial free block. heap_base is at apb byte address 0; write it only while busy
// is low. HEAP_BYTES must be a power of two.
module first_fit_boundary_tag_allocator import fbta_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        result
);

  logic [31:0] heap_base;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_HEAP_BASE) ? heap_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_BASE[2]) begin
      heap_base <= {pwdata[31:2], 2'b00};
    end
  end

  fbta_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .heap_base (heap_base),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

endmodule

/* design/fbta_mem.sv */
// heap word memory, one port, registered read data
// depends on nothing
`timescale 1ns / 1ps

module fbta_mem #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] addr,
  input  logic [31:0]      wd,
  output logic [31:0]      rd
);

  logic [31:0] mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end

endmodule

/* design/fbta_seq.sv */
// allocator sequencer: walks the free list and edits tags through one memory port
// depends on fbta_pkg and fbta_mem
`timescale 1ns / 1ps

module fbta_seq import fbta_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  input  logic [31:0] heap_base,
  output logic        busy,
  output logic        done,
  output rsp_t        result
);

  localparam int IDX_W = $clog2(HEAP_BYTES / 4);
  localparam int unsigned WALK_LIMIT = HEAP_BYTES / 24 + 1;
  localparam int CNT_W = $clog2(WALK_LIMIT + 1);
  localparam logic [31:0] HEAP = 32'(HEAP_BYTES);

  state_t state, ret;
  logic [2:0] icnt;
  logic [CNT_W-1:0] walk;
  logic [31:0] head;
  logic empty;
  logic [31:0] cur, block, rem, fb, un, lp, lx, jl, jr, rs, total, hdr, nh, ph;
  logic succ_free, pred_free;

  logic [31:0] moff, mwd, q;
  logic mwe;
  logic [32:0] hsum;
  logic [32:0] plo, phi;
  logic [31:0] blk;

  fbta_mem #(.IDX_W(IDX_W)) u_mem (
    .clk  (clk),
    .we   (mwe),
    .addr (moff[IDX_W+1:2]),
    .wd   (mwd),
    .rd   (q)
  );

  assign hsum = {1'b0, hdr} + {1'b0, q};
  assign plo = {1'b0, heap_base} + {1'b0, HDR_BYTES};
  assign phi = {1'b0, heap_base} + {1'b0, HEAP} - {1'b0, MIN_BLOCK};
  assign blk = ((32'(req.req_size) + 32'd3) & ~32'd3) + HDR_BYTES + FTR_BYTES;
  assign busy = (state != S_IDLE);

  always_comb begin
    moff = '0;
    mwe = 1'b0;
    mwd = '0;
    case (state)
      S_INIT: begin
        mwe = 1'b1;
        case (icnt)
          3'd0: begin moff = 32'd0; mwd = HEAP; end
          3'd1: moff = 32'd4;
          3'd2: moff = 32'd8;
          3'd3: moff = 32'd12;
          default: begin moff = HEAP - FTR_BYTES; mwd = HEAP; end
        endcase
      end
      A_RD: moff = cur;
      A_SZ: moff = cur + 32'd8;
      A_FL0: moff = cur + 32'd4;
      A_FL1: begin mwe = 1'b1; moff = cur + 32'd4; mwd = q | 32'd1; end
      P_W0: begin mwe = 1'b1; moff = cur; mwd = block; end
      P_F0: moff = cur + 32'd4;
      P_F1: begin mwe = 1'b1; moff = cur + 32'd4; mwd = q | 32'd1; end
      P_W2: begin mwe = 1'b1; moff = cur + block - FTR_BYTES; mwd = block; end
      P_W3: begin mwe = 1'b1; moff = fb; mwd = rem; end
      P_F2: moff = fb + 32'd4;
      P_F3: begin mwe = 1'b1; moff = fb + 32'd4; mwd = q & ~32'd1; end
      P_W4: begin mwe = 1'b1; moff = fb + rem - FTR_BYTES; mwd = rem; end
      P_P: moff = cur + 32'd12;
      P_X: moff = cur + 32'd8;
      P_Y: begin mwe = 1'b1; moff = fb + 32'd8; mwd = q; end
      P_Z: begin mwe = 1'b1; moff = fb + 32'd12; mwd = lp; end
      P_PW: begin
        mwe = lp[31];
        moff = {1'b0, lp[30:0]} + 32'd8;
        mwd = fb | LINK_VALID;
      end
      P_XW: begin
        mwe = lx[31];
        moff = {1'b0, lx[30:0]} + 32'd12;
        mwd = fb | LINK_VALID;
      end
      U_P: moff = un + 32'd12;
      U_X: moff = un + 32'd8;
      U_W1: begin mwe = lp[31]; moff = {1'b0, lp[30:0]} + 32'd8; mwd = q; end
      U_W2: begin mwe = lx[31]; moff = {1'b0, lx[30:0]} + 32'd12; mwd = lp; end
      J_0: moff = jr;
      J_1: moff = jl;
      J_2: begin mwe = 1'b1; moff = jl; mwd = q + rs; end
      J_3: begin mwe = 1'b1; moff = jr + rs - FTR_BYTES; mwd = total; end
      F_RF: moff = hdr + 32'd4;
      F_FL: begin mwe = q[0]; moff = hdr + 32'd4; mwd = q & ~32'd1; end
      F_RS: moff = hdr;
      F_SZ: moff = hsum[31:0] + 32'd4;
      F_PV: moff = hdr - FTR_BYTES;
      F_PF: moff = hdr - q + 32'd4;
      F_PUSH: begin
        mwe = !pred_free;
        moff = hdr + 32'd8;
        mwd = empty ? 32'd0 : (head | LINK_VALID);
      end
      F_P2: begin mwe = 1'b1; moff = hdr + 32'd12; mwd = '0; end
      F_P3: begin mwe = !empty; moff = head + 32'd12; mwd = hdr | LINK_VALID; end
      default: moff = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      icnt <= '0;
      head <= '0;
      empty <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          icnt <= icnt + 3'd1;
          if (icnt == 3'd4) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (req.req_type == REQ_FREE) begin
              if (({1'b0, req.free_address} < plo) || ({1'b0, req.free_address} >= phi)
                  || (req.free_address[1:0] != 2'd0)) begin
                done <= 1'b1;
                result <= '{status: ST_INVAL, payload_address: '0};
              end else begin
                hdr <= req.free_address - heap_base - HDR_BYTES;
                state <= F_RF;
              end
            end else if (req.req_size == '0) begin
              done <= 1'b1;
              result <= '{status: ST_INVAL, payload_address: '0};
            end else if (blk > HEAP || empty) begin
              done <= 1'b1;
              result <= '{status: ST_NOMEM, payload_address: '0};
            end else begin
              block <= blk;
              cur <= head;
              walk <= '0;
              state <= A_RD;
            end
          end
        end
        A_RD: state <= A_SZ;
        A_SZ: begin
          if (q >= block) begin
            rem <= q - block;
            fb <= cur + block;
            if (q - block >= MIN_BLOCK) begin
              state <= P_W0;
            end else begin
              un <= cur;
              ret <= A_FL0;
              state <= U_P;
            end
          end else begin
            state <= A_NX;
          end
        end
        A_NX: begin
          cur <= {1'b0, q[30:0]};
          if (!q[31] || walk == CNT_W'(WALK_LIMIT - 1)) begin
            done <= 1'b1;
            result <= '{status: ST_NOMEM, payload_address: '0};
            state <= S_IDLE;
          end else begin
            walk <= walk + 1'b1;
            state <= A_RD;
          end
        end
        A_FL0: state <= A_FL1;
        A_FL1, P_XW: begin
          done <= 1'b1;
          result <= '{status: ST_OK, payload_address: heap_base + cur + HDR_BYTES};
          state <= S_IDLE;
        end
        P_W0: state <= P_F0;
        P_F0: state <= P_F1;
        P_F1: state <= P_W2;
        P_W2: state <= P_W3;
        P_W3: state <= P_F2;
        P_F2: state <= P_F3;
        P_F3: state <= P_W4;
        P_W4: state <= P_P;
        P_P: state <= P_X;
        P_X: begin lp <= q; state <= P_Y; end
        P_Y: begin lx <= q; state <= P_Z; end
        P_Z: state <= P_PW;
        P_PW: begin
          if (!lp[31]) begin
            head <= {1'b0, fb[30:0]};
            empty <= 1'b0;
          end
          state <= P_XW;
        end
        U_P: state <= U_X;
        U_X: begin lp <= q; state <= U_W1; end
        U_W1: begin
          lx <= q;
          if (!lp[31]) begin
            if (q[31]) begin
              head <= {1'b0, q[30:0]};
              empty <= 1'b0;
            end else begin
              empty <= 1'b1;
            end
          end
          state <= U_W2;
        end
        U_W2: state <= ret;
        J_0: state <= J_1;
        J_1: begin rs <= q; state <= J_2; end
        J_2: begin total <= q + rs; state <= J_3; end
        J_3: state <= ret;
        F_RF: state <= F_FL;
        F_FL: begin
          if (!q[0]) begin
            done <= 1'b1;
            result <= '{status: ST_INVAL, payload_address: '0};
            state <= S_IDLE;
          end else begin
            state <= F_RS;
          end
        end
        F_RS: state <= F_SZ;
        F_SZ: begin
          if (hsum < {1'b0, HEAP}) begin
            nh <= hsum[31:0];
            state <= F_NF;
          end else begin
            succ_free <= 1'b0;
            state <= F_PV;
          end
        end
        F_NF: begin succ_free <= !q[0]; state <= F_PV; end
        F_PV: begin
          if (hdr != '0) begin
            state <= F_PF;
          end else begin
            pred_free <= 1'b0;
            state <= F_MG;
          end
        end
        F_PF: begin ph <= hdr - q; state <= F_PF2; end
        F_PF2: begin pred_free <= !q[0]; state <= F_MG; end
        F_MG: begin
          if (pred_free) begin
            jl <= ph;
            jr <= hdr;
            hdr <= ph;
            ret <= F_J1;
            state <= J_0;
          end else begin
            state <= F_J1;
          end
        end
        F_J1: begin
          if (succ_free) begin
            un <= nh;
            ret <= F_J2;
            state <= U_P;
          end else begin
            state <= F_PUSH;
          end
        end
        F_J2: begin
          jl <= hdr;
          jr <= nh;
          ret <= F_PUSH;
          state <= J_0;
        end
        F_PUSH: begin
          if (pred_free) begin
            done <= 1'b1;
            result <= '{status: ST_OK, payload_address: '0};
            state <= S_IDLE;
          end else begin
            state <= F_P2;
          end
        end
        F_P2: state <= F_P3;
        F_P3: begin
          head <= {1'b0, hdr[30:0]};
          empty <= 1'b0;
          done <= 1'b1;
          result <= '{status: ST_OK, payload_address: '0};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/first_fit_boundary_tag_allocator_test.sv */
// self-checking testbench for the first-fit boundary-tag heap allocator
// depends on fbta_pkg and first_fit_boundary_tag_allocator; keeps a mirror of the heap
`timescale 1ns / 1ps

module first_fit_boundary_tag_allocator_test;
  import fbta_pkg::*;

  localparam int unsigned HB = HEAP_BYTES_DEF;
  localparam int unsigned NWORDS = HB / 4;
  localparam int LIMIT = 20000000;

  class heap_mirror;
    logic [31:0] words[NWORDS];
    bit touched[NWORDS];
    logic [31:0] head;
    logic [31:0] base;
    bit empty;
    rsp_t pending[$];
    int mismatches;

    function new();
      foreach (words[i]) begin
        words[i] = '0;
        touched[i] = 0;
      end
      put(0, HB);
      put(HB - 4, HB);
      head = 0;
      empty = 0;
      base = 0;
      mismatches = 0;
    endfunction

    function logic [31:0] get(logic [31:0] off);
      return words[off[13:2]];
    endfunction

    function void put(logic [31:0] off, logic [31:0] v);
      words[off[13:2]] = v;
      touched[off[13:2]] = 1;
    endfunction

    function void unlink(logic [31:0] n);
      logic [31:0] p, x;
      p = get(n + 12);
      x = get(n + 8);
      if (p[31]) put({1'b0, p[30:0]} + 8, x);
      else if (x[31]) begin
        head = {1'b0, x[30:0]};
        empty = 0;
      end else empty = 1;
      if (x[31]) put({1'b0, x[30:0]} + 12, p);
    endfunction

    function void push_front(logic [31:0] n);
      put(n + 8, empty ? 32'd0 : (head | LINK_VALID));
      put(n + 12, 0);
      if (!empty) put(head + 12, n | LINK_VALID);
      head = {1'b0, n[30:0]};
      empty = 0;
    endfunction

    function void swap_in(logic [31:0] old, logic [31:0] nw);
      logic [31:0] p, x;
      p = get(old + 12);
      x = get(old + 8);
      put(nw + 8, x);
      put(nw + 12, p);
      if (p[31]) put({1'b0, p[30:0]} + 8, nw | LINK_VALID);
      else begin
        head = {1'b0, nw[30:0]};
        empty = 0;
      end
      if (x[31]) put({1'b0, x[30:0]} + 12, nw | LINK_VALID);
    endfunction

    function void join_blocks(logic [31:0] l, logic [31:0] r);
      logic [31:0] rs, total;
      rs = get(r);
      total = get(l) + rs;
      put(l, total);
      put(r + rs - FTR_BYTES, total);
    endfunction

    function logic [1:0] alloc(logic [31:0] size, output logic [31:0] addr);
      logic [31:0] blk, cur, sz, nx, rem, fb;
      int i;
      addr = 0;
      if (size == 0) return ST_INVAL;
      blk = HDR_BYTES + ((size + 3) & 32'hFFFF_FFFC) + FTR_BYTES;
      if (blk > HB || empty) return ST_NOMEM;
      cur = head;
      for (i = 0; i < HB / 24 + 1; i++) begin
        sz = get(cur);
        if (sz >= blk) begin
          rem = sz - blk;
          if (rem >= MIN_BLOCK) begin
            fb = cur + blk;
            put(cur, blk);
            put(cur + 4, get(cur + 4) | 32'd1);
            put(cur + blk - FTR_BYTES, blk);
            put(fb, rem);
            put(fb + 4, get(fb + 4) & 32'hFFFF_FFFE);
            put(fb + rem - FTR_BYTES, rem);
            swap_in(cur, fb);
          end else begin
            unlink(cur);
            put(cur + 4, get(cur + 4) | 32'd1);
          end
          addr = base + cur + HDR_BYTES;
          return ST_OK;
        end
        nx = get(cur + 8);
        if (!nx[31]) break;
        cur = {1'b0, nx[30:0]};
      end
      return ST_NOMEM;
    endfunction

    function bit rejected_early(logic [31:0] ptr);
      logic [63:0] p, b;
      p = ptr;
      b = base;
      return p < b + HDR_BYTES || p >= b + HB - MIN_BLOCK || ptr[1:0] != 0;
    endfunction

    function bit stale_safe(logic [31:0] ptr);
      logic [31:0] hdr;
      logic [11:0] fi;
      if (rejected_early(ptr)) return 1;
      hdr = ptr - base - HDR_BYTES;
      fi = hdr[13:2] + 12'd1;
      return touched[fi] && !words[fi][0];
    endfunction

    function logic [1:0] release_block(logic [31:0] ptr);
      logic [31:0] hdr, flags, sz, nh, ph, t;
      bit nf, pf;
      nf = 0;
      pf = 0;
      nh = 0;
      ph = 0;
      if (rejected_early(ptr)) return ST_INVAL;
      hdr = ptr - base - HDR_BYTES;
      flags = get(hdr + 4);
      if (!flags[0]) return ST_INVAL;
      put(hdr + 4, flags & 32'hFFFF_FFFE);
      sz = get(hdr);
      if (64'(hdr) + 64'(sz) < HB) begin
        nh = hdr + sz;
        t = get(nh + 4);
        nf = !t[0];
      end
      if (hdr != 0) begin
        ph = hdr - get(hdr - FTR_BYTES);
        t = get(ph + 4);
        pf = !t[0];
      end
      if (pf) begin
        join_blocks(ph, hdr);
        hdr = ph;
      end
      if (nf) begin
        unlink(nh);
        join_blocks(hdr, nh);
      end
      if (!pf) push_front(hdr);
      return ST_OK;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t e;
      logic [31:0] a;
      a = 0;
      if (r.req_type == REQ_FREE) e.status = release_block(r.free_address);
      else e.status = alloc({17'd0, r.req_size}, a);
      e.payload_address = (e.status == ST_OK) ? a : 32'd0;
      pending.push_back(e);
      return e;
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d addr=%h",
                                       got.status, got.payload_address);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.payload_address !== e.payload_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d addr=%h, got status=%0d addr=%h",
                   e.status, e.payload_address, got.status, got.payload_address);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t result;

  heap_mirror sb = new();
  logic [31:0] live[$];
  logic [31:0] stale[$];
  int idle_pct;
  int cycles = 0;

  first_fit_boundary_tag_allocator DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .req(req), .busy(busy), .done(done), .result(result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_response(result);
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(req_t r, output rsp_t e);
    int idx[$];
    logic [31:0] off;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    req <= r;
    do @(posedge clk); while (busy);
    e = sb.note_request(r);
    if (e.status == ST_OK) begin
      if (r.req_type == REQ_ALLOC) live.push_back(e.payload_address - sb.base);
      else begin
        off = r.free_address - sb.base;
        idx = live.find_first_index(x) with (x == off);
        if (idx.size() > 0) live.delete(idx[0]);
        stale.push_back(off);
      end
    end
  endtask

  task automatic alloc_item(int unsigned sz, output logic [31:0] a);
    req_t r;
    rsp_t e;
    r.req_type = REQ_ALLOC;
    r.req_size = sz[14:0];
    r.free_address = $urandom;
    issue(r, e);
    a = e.payload_address;
  endtask

  task automatic free_item(logic [31:0] addr);
    req_t r;
    rsp_t e;
    r.req_type = REQ_FREE;
    r.req_size = 15'($urandom);
    r.free_address = addr;
    issue(r, e);
  endtask

  task automatic random_item();
    logic [31:0] a;
    int unsigned k, pick;
    k = $urandom_range(99);
    if (live.size() == 0 || (live.size() < 40 ? k < 55 : k < 30)) begin
      pick = $urandom_range(99);
      if (pick < 80) alloc_item($urandom_range(1, 256), a);
      else if (pick < 93) alloc_item($urandom_range(257, 4000), a);
      else if (pick < 97) alloc_item($urandom_range(0, 32767), a);
      else alloc_item($urandom_range(16360, 16384), a);
    end else begin
      pick = $urandom_range(99);
      if (pick < 82) free_item(sb.base + live[$urandom_range(live.size() - 1)]);
      else if (pick < 90 && stale.size() > 0) begin
        a = sb.base + stale[$urandom_range(stale.size() - 1)];
        if (sb.stale_safe(a)) free_item(a);
        else free_item(sb.base + live[$urandom_range(live.size() - 1)]);
      end else if (pick < 95) begin
        a = $urandom;
        if (!sb.rejected_early(a)) a[0] = 1'b1;
        free_item(a);
      end else free_item(sb.base + live[$urandom_range(live.size() - 1)]
                         + $urandom_range(1, 3));
    end
  endtask

  task automatic write_base(logic [31:0] v);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= REG_HEAP_BASE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.base = v & 32'hFFFF_FFFC;
  endtask

  task automatic random_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) random_item();
    start <= 0;
  endtask

  initial begin
    logic [31:0] a0, a1, a2, a3;
    idle_pct = 31;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_base(32'h0);

    alloc_item(0, a0);
    alloc_item(16384, a0);
    alloc_item(32767, a0);
    alloc_item(16364, a0);
    alloc_item(4, a1);
    free_item(a0);
    alloc_item(100, a1);
    alloc_item(100, a2);
    alloc_item(100, a3);
    alloc_item(1, a0);
    free_item(a2);
    free_item(a1);
    free_item(a3);
    free_item(a3);
    free_item(sb.base);
    free_item(sb.base + HB - 24);
    free_item(a0 + 2);
    free_item(32'hFFFF_FFFF);
    alloc_item(96, a1);
    alloc_item(16384 - 48, a2);
    free_item(a0);
    random_phase(480, 31);

    write_base(32'hFFFF_FFFF);
    random_phase(60, 31);
    write_base(32'h1234_5673);
    random_phase(480, 79);
    write_base(32'h8000_0000);
    random_phase(480, 0);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
